/* rtl/core/trcp_pkg.sv */
// ----------------------------------------------------------------------------
// trcp_pkg
// Shared types, codes and palette lookups for the text cell pixel renderer.
// ----------------------------------------------------------------------------
package trcp_pkg;

  // Field widths of the pixel beat
  localparam int unsigned CELL_ROW_W   = 5;
  localparam int unsigned CELL_COL_W   = 6;
  localparam int unsigned PIX_ROW_W    = 4;
  localparam int unsigned PIX_COL_W    = 3;
  localparam int unsigned ATTR_W       = 15;
  localparam int unsigned GLYPH_W      = 8;
  localparam int unsigned GLYPH_SIZE_W = 4;
  localparam int unsigned COLOR_W      = 32;
  localparam int unsigned FRAME_W      = 9;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 6;

  // Widest glyph row in dots
  localparam logic [GLYPH_SIZE_W-1:0] GLYPH_MAX_WIDE = 4'd8;

  localparam logic [COLOR_W-1:0] COLOR_CLEAR = 32'h0000_0000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FAST_BLINK_PHASE = 3'd0,
    CFG_SLOW_BLINK_PHASE = 3'd1,
    CFG_CURSOR_ROW       = 3'd2,
    CFG_CURSOR_COLUMN    = 3'd3,
    CFG_CURSOR_SHOWN     = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    INTEN_NORMAL = 2'd0,
    INTEN_FAINT  = 2'd1,
    INTEN_BOLD   = 2'd2
  } intensity_t;

  // Blink rates: off, long period (slow), short period (fast)
  typedef enum logic [1:0] {
    BLINK_OFF   = 2'd0,
    BLINK_LONG  = 2'd1,
    BLINK_SHORT = 2'd2
  } blink_t;

  typedef enum logic [1:0] {
    UL_NONE   = 2'd0,
    UL_SINGLE = 2'd1,
    UL_DOUBLE = 2'd2
  } underline_t;

  // One pixel beat as held in the input stage
  typedef struct packed {
    logic [CELL_ROW_W-1:0]   cell_row;
    logic [CELL_COL_W-1:0]   cell_column;
    logic [PIX_ROW_W-1:0]    pixel_row;
    logic [PIX_COL_W-1:0]    pixel_column;
    logic [ATTR_W-1:0]       cell_attributes;
    logic [GLYPH_W-1:0]      glyph_row_bits;
    logic [GLYPH_SIZE_W-1:0] glyph_bits_wide;
    logic [GLYPH_SIZE_W-1:0] glyph_rows_tall;
  } pixel_in_t;

  // Choose one of the three intensity shades; unknown codes fall to normal
  function automatic logic [COLOR_W-1:0] pick_shade(
    input logic [1:0]         inten,
    input logic [COLOR_W-1:0] normal,
    input logic [COLOR_W-1:0] faint,
    input logic [COLOR_W-1:0] bold
  );
    logic [COLOR_W-1:0] shade;
    case (inten)
      INTEN_FAINT: shade = faint;
      INTEN_BOLD:  shade = bold;
      default:     shade = normal;
    endcase
    return shade;
  endfunction

  // Foreground palette; codes 9 and up are transparent
  function automatic logic [COLOR_W-1:0] fore_color(
    input logic [3:0] code,
    input logic [1:0] inten
  );
    logic [COLOR_W-1:0] color;
    case (code)
      4'd0:    color = pick_shade(inten, 32'hffeeee88, 32'hff888888, 32'hffffff88);
      4'd1:    color = pick_shade(inten, 32'hff000000, 32'hff000000, 32'hff000000);
      4'd2:    color = pick_shade(inten, 32'hffee0000, 32'hff880000, 32'hffff0000);
      4'd3:    color = pick_shade(inten, 32'hff00ee00, 32'hff008800, 32'hff00ff00);
      4'd4:    color = pick_shade(inten, 32'hffeeee00, 32'hff888800, 32'hffffff00);
      4'd5:    color = pick_shade(inten, 32'hff0000ee, 32'hff000088, 32'hff0000ff);
      4'd6:    color = pick_shade(inten, 32'hffee00ee, 32'hff880088, 32'hffff00ff);
      4'd7:    color = pick_shade(inten, 32'hff00eeee, 32'hff008888, 32'hff00ffff);
      4'd8:    color = pick_shade(inten, 32'hffeeeeee, 32'hff888888, 32'hffffffff);
      default: color = COLOR_CLEAR;
    endcase
    return color;
  endfunction

  // Background palette; code 0 and codes 9 and up are transparent
  function automatic logic [COLOR_W-1:0] back_color(input logic [3:0] code);
    logic [COLOR_W-1:0] color;
    case (code)
      4'd1:    color = 32'hff000000;
      4'd2:    color = 32'hffee0000;
      4'd3:    color = 32'hff00ee00;
      4'd4:    color = 32'hffeeee00;
      4'd5:    color = 32'hff0000ee;
      4'd6:    color = 32'hffee00ee;
      4'd7:    color = 32'hff00eeee;
      4'd8:    color = 32'hffeeeeee;
      default: color = COLOR_CLEAR;
    endcase
    return color;
  endfunction

endpackage

/* rtl/core/trcp_pixel_if.sv */
// ----------------------------------------------------------------------------
// trcp_pixel_if
// Valid/ready channel carrying one pixel beat into the renderer.
// ----------------------------------------------------------------------------
interface trcp_pixel_if;
  logic                                valid;
  logic                                ready;
  logic [trcp_pkg::CELL_ROW_W-1:0]     cell_row;
  logic [trcp_pkg::CELL_COL_W-1:0]     cell_column;
  logic [trcp_pkg::PIX_ROW_W-1:0]      pixel_row;
  logic [trcp_pkg::PIX_COL_W-1:0]      pixel_column;
  logic [trcp_pkg::ATTR_W-1:0]         cell_attributes;
  logic [trcp_pkg::GLYPH_W-1:0]        glyph_row_bits;
  logic [trcp_pkg::GLYPH_SIZE_W-1:0]   glyph_bits_wide;
  logic [trcp_pkg::GLYPH_SIZE_W-1:0]   glyph_rows_tall;

  modport source (
    output valid, cell_row, cell_column, pixel_row, pixel_column,
           cell_attributes, glyph_row_bits, glyph_bits_wide, glyph_rows_tall,
    input  ready
  );

  modport sink (
    input  valid, cell_row, cell_column, pixel_row, pixel_column,
           cell_attributes, glyph_row_bits, glyph_bits_wide, glyph_rows_tall,
    output ready
  );
endinterface

/* rtl/core/trcp_color_if.sv */
// ----------------------------------------------------------------------------
// trcp_color_if
// Valid/ready channel carrying one rendered pixel beat out of the renderer.
// ----------------------------------------------------------------------------
interface trcp_color_if;
  logic                           valid;
  logic                           ready;
  logic [trcp_pkg::COLOR_W-1:0]   pixel_color;
  logic [trcp_pkg::FRAME_W-1:0]   frame_x;
  logic [trcp_pkg::FRAME_W-1:0]   frame_y;

  modport source (
    output valid, pixel_color, frame_x, frame_y,
    input  ready
  );

  modport sink (
    input  valid, pixel_color, frame_x, frame_y,
    output ready
  );
endinterface

/* rtl/core/trcp_cfg_if.sv */
// ----------------------------------------------------------------------------
// trcp_cfg_if
// Register write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface trcp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [trcp_pkg::CFG_INDEX_W-1:0]   index;
  logic [trcp_pkg::CFG_DATA_W-1:0]    data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

/* rtl/core/text_cell_pixel_renderer.sv */
// ----------------------------------------------------------------------------
// text_cell_pixel_renderer
// Pipeline: each input beat is registered in the input stage, then in the result stage.
// Throughput: one pixel per cycle; the result register stalls only on out_ch.ready.
// Reset: synchronous active-low rst_n clears both stage valids and the
// registers (blink phases and cursor position to 0, cursor shown to 1).
// ----------------------------------------------------------------------------
module text_cell_pixel_renderer #(
  parameter int unsigned GRID_ROWS    = 32,
  parameter int unsigned GRID_COLUMNS = 64,
  parameter int unsigned CELL_WIDTH   = 8,
  parameter int unsigned CELL_HEIGHT  = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  trcp_pixel_if.sink         in_ch,
  trcp_color_if.source       out_ch,
  trcp_cfg_if.sink           cfg_ch
);

  localparam int unsigned MUL_W = 16;

  // Configuration registers
  logic                                fast_phase_r;
  logic                                slow_phase_r;
  logic [trcp_pkg::CELL_ROW_W-1:0]     cursor_row_r;
  logic [trcp_pkg::CELL_COL_W-1:0]     cursor_col_r;
  logic                                cursor_shown_r;

  // Pipeline registers
  logic                                s1_valid_r;
  trcp_pkg::pixel_in_t                 s1_data_r;
  logic                                out_valid_r;
  logic [trcp_pkg::COLOR_W-1:0]        out_color_r;
  logic [trcp_pkg::FRAME_W-1:0]        out_x_r;
  logic [trcp_pkg::FRAME_W-1:0]        out_y_r;

  // Render logic
  logic                                s1_advance;
  logic                                in_fire;
  logic [3:0]                          fg_code;
  logic [3:0]                          bg_code;
  logic [1:0]                          inten;
  logic                                negative;
  trcp_pkg::blink_t                    blink;
  trcp_pkg::underline_t                uline;
  logic [trcp_pkg::COLOR_W-1:0]        fg_base;
  logic [trcp_pkg::COLOR_W-1:0]        bg_base;
  logic                                blink_on;
  logic                                cursor_hit;
  logic                                swap;
  logic [trcp_pkg::COLOR_W-1:0]        fg_final;
  logic [trcp_pkg::COLOR_W-1:0]        bg_final;
  logic [trcp_pkg::GLYPH_SIZE_W-1:0]   wide_clamp;
  logic [trcp_pkg::GLYPH_SIZE_W-1:0]   tall;
  logic [trcp_pkg::GLYPH_SIZE_W-1:0]   prow;
  logic [trcp_pkg::GLYPH_SIZE_W-1:0]   pcol_ext;
  logic [trcp_pkg::GLYPH_SIZE_W-1:0]   bit_idx;
  logic                                pix_visible;
  logic                                ul_bottom;
  logic                                ul_second;
  logic                                glyph_dot;
  logic [trcp_pkg::COLOR_W-1:0]        color_nxt;
  logic [MUL_W-1:0]                    frame_x_full;
  logic [MUL_W-1:0]                    frame_y_full;

  // Handshake: result register parts the two sides
  assign s1_advance = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_advance;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_phase_r   <= 1'b0;
      slow_phase_r   <= 1'b0;
      cursor_row_r   <= '0;
      cursor_col_r   <= '0;
      cursor_shown_r <= 1'b1;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        trcp_pkg::CFG_FAST_BLINK_PHASE: fast_phase_r   <= cfg_ch.data[0];
        trcp_pkg::CFG_SLOW_BLINK_PHASE: slow_phase_r   <= cfg_ch.data[0];
        trcp_pkg::CFG_CURSOR_ROW:
          cursor_row_r <= cfg_ch.data[trcp_pkg::CELL_ROW_W-1:0];
        trcp_pkg::CFG_CURSOR_COLUMN:
          cursor_col_r <= cfg_ch.data[trcp_pkg::CELL_COL_W-1:0];
        trcp_pkg::CFG_CURSOR_SHOWN:     cursor_shown_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Input stage: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // Input stage: capture the beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r.cell_row        <= in_ch.cell_row;
      s1_data_r.cell_column     <= in_ch.cell_column;
      s1_data_r.pixel_row       <= in_ch.pixel_row;
      s1_data_r.pixel_column    <= in_ch.pixel_column;
      s1_data_r.cell_attributes <= in_ch.cell_attributes;
      s1_data_r.glyph_row_bits  <= in_ch.glyph_row_bits;
      s1_data_r.glyph_bits_wide <= in_ch.glyph_bits_wide;
      s1_data_r.glyph_rows_tall <= in_ch.glyph_rows_tall;
    end
  end

  // Decode attributes and look up palettes
  always_comb begin
    fg_code  = s1_data_r.cell_attributes[3:0];
    bg_code  = s1_data_r.cell_attributes[7:4];
    inten    = s1_data_r.cell_attributes[9:8];
    negative = s1_data_r.cell_attributes[10];
    blink    = trcp_pkg::blink_t'(s1_data_r.cell_attributes[12:11]);
    uline    = trcp_pkg::underline_t'(s1_data_r.cell_attributes[14:13]);
    fg_base  = trcp_pkg::fore_color(fg_code, inten);
    bg_base  = trcp_pkg::back_color(bg_code);
  end

  // Swap colors for polarity against blink phase, then again at the cursor
  always_comb begin
    blink_on   = ((blink == trcp_pkg::BLINK_SHORT) && fast_phase_r) ||
                 ((blink == trcp_pkg::BLINK_LONG) && slow_phase_r);
    cursor_hit = (s1_data_r.cell_row == cursor_row_r) &&
                 (s1_data_r.cell_column == cursor_col_r) && cursor_shown_r;
    swap       = (negative ^ blink_on) ^ cursor_hit;
    fg_final   = swap ? bg_base : fg_base;
    bg_final   = swap ? fg_base : bg_base;
  end

  // Pick the pixel: clear outside the box, underline rows, glyph dot
  always_comb begin
    wide_clamp = (s1_data_r.glyph_bits_wide > trcp_pkg::GLYPH_MAX_WIDE) ?
                 trcp_pkg::GLYPH_MAX_WIDE : s1_data_r.glyph_bits_wide;
    tall       = s1_data_r.glyph_rows_tall;
    prow       = s1_data_r.pixel_row;
    pcol_ext   = {1'b0, s1_data_r.pixel_column};
    bit_idx    = wide_clamp - pcol_ext - 4'd1;

    pix_visible = (32'(s1_data_r.cell_row) < GRID_ROWS) &&
                  (32'(s1_data_r.cell_column) < GRID_COLUMNS) &&
                  (32'(prow) < CELL_HEIGHT) &&
                  (32'(pcol_ext) < CELL_WIDTH) &&
                  (pcol_ext < wide_clamp) && (prow < tall);

    ul_bottom = ((uline == trcp_pkg::UL_SINGLE) || (uline == trcp_pkg::UL_DOUBLE)) &&
                (prow == tall - 4'd1);
    ul_second = (uline == trcp_pkg::UL_DOUBLE) && (tall >= 4'd2) &&
                (prow == tall - 4'd2);
    glyph_dot = s1_data_r.glyph_row_bits[bit_idx[2:0]];

    if (!pix_visible) begin
      color_nxt = trcp_pkg::COLOR_CLEAR;
    end else if (ul_bottom || ul_second || glyph_dot) begin
      color_nxt = fg_final;
    end else begin
      color_nxt = bg_final;
    end
  end

  // Frame position, wrapped to the output width
  assign frame_x_full = MUL_W'(s1_data_r.cell_column) * MUL_W'(CELL_WIDTH) +
                        MUL_W'(s1_data_r.pixel_column);
  assign frame_y_full = MUL_W'(s1_data_r.cell_row) * MUL_W'(CELL_HEIGHT) +
                        MUL_W'(s1_data_r.pixel_row);

  // Result stage: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Result stage: hold while stalled, load on advance
  always_ff @(posedge clk) begin
    if (s1_advance && s1_valid_r) begin
      out_color_r <= color_nxt;
      out_x_r     <= frame_x_full[trcp_pkg::FRAME_W-1:0];
      out_y_r     <= frame_y_full[trcp_pkg::FRAME_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_color = out_color_r;
  assign out_ch.frame_x     = out_x_r;
  assign out_ch.frame_y     = out_y_r;

`ifndef SYNTHESIS
  // An accepted beat lands in the input stage
  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted beat not held in input stage");

  // A held beat moves into an empty result register
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("input stage did not advance into empty result register");

  // Pixels outside the glyph box or grid come out clear
  a_clear_outside: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_advance && !pix_visible) |=>
      (out_color_r == trcp_pkg::COLOR_CLEAR))
    else $error("pixel outside the box was painted");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");
`endif

endmodule

/* sim/text_cell_pixel_renderer_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_cell_pixel_renderer_checker
// Watches the pixel, color and register channels of the renderer. Keeps its
// own copy of the blink and cursor registers, predicts the color and frame
// position of every accepted pixel beat, and compares each result beat, in
// order, with the oldest prediction.
// ----------------------------------------------------------------------------
module text_cell_pixel_renderer_checker (
  input  logic  clk,
  input  logic  rst_n,
  trcp_pixel_if px_mon,
  trcp_color_if color_mon,
  trcp_cfg_if   cfg_mon,
  output int    fail_count,
  output int    pending_count,
  output int    checked_count
);

  localparam int GRID_ROWS    = 32;
  localparam int GRID_COLUMNS = 64;
  localparam int CELL_WIDTH   = 8;
  localparam int CELL_HEIGHT  = 12;
  localparam int LAST_COLOR   = 9;

  // Foreground shades per color code: normal, faint, bold
  localparam logic [trcp_pkg::COLOR_W-1:0] FORE_LUT [0:9][0:2] = '{
    '{32'hffeeee88, 32'hff888888, 32'hffffff88},
    '{32'hff000000, 32'hff000000, 32'hff000000},
    '{32'hffee0000, 32'hff880000, 32'hffff0000},
    '{32'hff00ee00, 32'hff008800, 32'hff00ff00},
    '{32'hffeeee00, 32'hff888800, 32'hffffff00},
    '{32'hff0000ee, 32'hff000088, 32'hff0000ff},
    '{32'hffee00ee, 32'hff880088, 32'hffff00ff},
    '{32'hff00eeee, 32'hff008888, 32'hff00ffff},
    '{32'hffeeeeee, 32'hff888888, 32'hffffffff},
    '{32'h00000000, 32'h00000000, 32'h00000000}
  };

  localparam logic [trcp_pkg::COLOR_W-1:0] BACK_LUT [0:9] = '{
    32'h00000000, 32'hff000000, 32'hffee0000, 32'hff00ee00, 32'hffeeee00,
    32'hff0000ee, 32'hffee00ee, 32'hff00eeee, 32'hffeeeeee, 32'h00000000
  };

  typedef struct packed {
    logic [trcp_pkg::COLOR_W-1:0] pixel_color;
    logic [trcp_pkg::FRAME_W-1:0] frame_x;
    logic [trcp_pkg::FRAME_W-1:0] frame_y;
  } rendered_px_t;

  // Register copies
  logic                            fast_on;
  logic                            slow_on;
  logic [trcp_pkg::CELL_ROW_W-1:0] cursor_r;
  logic [trcp_pkg::CELL_COL_W-1:0] cursor_c;
  logic                            cursor_on;

  rendered_px_t pixels_due[$];

  // Work out color and frame position of one pixel under the current registers
  function automatic rendered_px_t render_pixel(input trcp_pkg::pixel_in_t p);
    rendered_px_t                 r;
    int                           fg_code;
    int                           bg_code;
    int                           shade;
    logic [1:0]                   blink_code;
    logic [1:0]                   ul_code;
    logic                         negative;
    logic                         blink_on;
    logic [trcp_pkg::COLOR_W-1:0] fg;
    logic [trcp_pkg::COLOR_W-1:0] bg;
    logic [trcp_pkg::COLOR_W-1:0] swap;
    int                           wide;
    int                           tall;
    int                           prow;
    int                           pcol;
    int                           crow;
    int                           ccol;
    fg_code = int'(p.cell_attributes[3:0]);
    bg_code = int'(p.cell_attributes[7:4]);
    if (fg_code > LAST_COLOR) fg_code = LAST_COLOR;
    if (bg_code > LAST_COLOR) bg_code = LAST_COLOR;
    case (p.cell_attributes[9:8])
      trcp_pkg::INTEN_FAINT: shade = 1;
      trcp_pkg::INTEN_BOLD:  shade = 2;
      default:               shade = 0;
    endcase
    negative   = p.cell_attributes[10];
    blink_code = p.cell_attributes[12:11];
    ul_code    = p.cell_attributes[14:13];
    fg = FORE_LUT[fg_code][shade];
    bg = BACK_LUT[bg_code];

    // Swap on polarity against blink phase, then again at the shown cursor
    blink_on = (blink_code == trcp_pkg::BLINK_SHORT && fast_on) ||
               (blink_code == trcp_pkg::BLINK_LONG && slow_on);
    if (negative != blink_on) begin
      swap = fg; fg = bg; bg = swap;
    end
    if (p.cell_row == cursor_r && p.cell_column == cursor_c && cursor_on) begin
      swap = fg; fg = bg; bg = swap;
    end

    wide = int'(p.glyph_bits_wide);
    if (wide > 8) wide = 8;
    tall = int'(p.glyph_rows_tall);
    prow = int'(p.pixel_row);
    pcol = int'(p.pixel_column);
    crow = int'(p.cell_row);
    ccol = int'(p.cell_column);

    // Paint: cleared outside the glyph box, underline rows, then glyph dots
    if (crow >= GRID_ROWS || ccol >= GRID_COLUMNS || prow >= CELL_HEIGHT ||
        pcol >= CELL_WIDTH || pcol >= wide || prow >= tall) begin
      r.pixel_color = 32'h00000000;
    end else if ((ul_code == trcp_pkg::UL_SINGLE || ul_code == trcp_pkg::UL_DOUBLE) &&
                 prow == tall - 1) begin
      r.pixel_color = fg;
    end else if (ul_code == trcp_pkg::UL_DOUBLE && tall >= 2 && prow == tall - 2) begin
      r.pixel_color = fg;
    end else if (p.glyph_row_bits[wide - pcol - 1]) begin
      r.pixel_color = fg;
    end else begin
      r.pixel_color = bg;
    end
    r.frame_x = trcp_pkg::FRAME_W'(ccol * CELL_WIDTH + pcol);
    r.frame_y = trcp_pkg::FRAME_W'(crow * CELL_HEIGHT + prow);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    rendered_px_t        want;
    trcp_pkg::pixel_in_t beat;
    if (!rst_n) begin
      fast_on       = 1'b0;
      slow_on       = 1'b0;
      cursor_r      = '0;
      cursor_c      = '0;
      cursor_on     = 1'b1;
      fail_count    = 0;
      checked_count = 0;
      pixels_due.delete();
    end else begin
      // Compare each result beat against the oldest prediction
      if (color_mon.valid && color_mon.ready) begin
        if (pixels_due.size() == 0) begin
          $error("result beat with no pixel pending: color %h x %0d y %0d",
                 color_mon.pixel_color, color_mon.frame_x, color_mon.frame_y);
          fail_count++;
        end else begin
          want = pixels_due.pop_front();
          checked_count++;
          if (color_mon.pixel_color !== want.pixel_color) begin
            $error("pixel_color: expected %h, got %h", want.pixel_color,
                   color_mon.pixel_color);
            fail_count++;
          end
          if (color_mon.frame_x !== want.frame_x) begin
            $error("frame_x: expected %0d, got %0d", want.frame_x, color_mon.frame_x);
            fail_count++;
          end
          if (color_mon.frame_y !== want.frame_y) begin
            $error("frame_y: expected %0d, got %0d", want.frame_y, color_mon.frame_y);
            fail_count++;
          end
        end
      end

      // Predict every accepted pixel beat
      if (px_mon.valid && px_mon.ready) begin
        beat.cell_row        = px_mon.cell_row;
        beat.cell_column     = px_mon.cell_column;
        beat.pixel_row       = px_mon.pixel_row;
        beat.pixel_column    = px_mon.pixel_column;
        beat.cell_attributes = px_mon.cell_attributes;
        beat.glyph_row_bits  = px_mon.glyph_row_bits;
        beat.glyph_bits_wide = px_mon.glyph_bits_wide;
        beat.glyph_rows_tall = px_mon.glyph_rows_tall;
        pixels_due.push_back(render_pixel(beat));
      end

      // Track register writes; they take effect for later beats
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          trcp_pkg::CFG_FAST_BLINK_PHASE: fast_on   = cfg_mon.data[0];
          trcp_pkg::CFG_SLOW_BLINK_PHASE: slow_on   = cfg_mon.data[0];
          trcp_pkg::CFG_CURSOR_ROW:
            cursor_r = cfg_mon.data[trcp_pkg::CELL_ROW_W-1:0];
          trcp_pkg::CFG_CURSOR_COLUMN:
            cursor_c = cfg_mon.data[trcp_pkg::CELL_COL_W-1:0];
          trcp_pkg::CFG_CURSOR_SHOWN:     cursor_on = cfg_mon.data[0];
          default: ;
        endcase
      end
    end
    pending_count = pixels_due.size();
  end

endmodule

/* sim/text_cell_pixel_renderer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_cell_pixel_renderer_tb
// Drives pixel beats into the renderer in random bursts while the result side
// stalls on its own pattern. A short directed list hits the field extremes,
// attribute codes, clipping and cursor cases; random phases follow, each under
// a fresh register setting written while the block is idle.
// ----------------------------------------------------------------------------
module text_cell_pixel_renderer_tb;

  localparam int CLK_HALF         = 5;
  localparam int RESET_CYCLES     = 6;
  localparam int RANDOM_PHASES    = 8;
  localparam int PIXELS_PER_PHASE = 100;
  localparam int DRAIN_CYCLES     = 4;
  localparam int RUN_LIMIT_NS     = 2_000_000;
  localparam int LAST_COLOR       = 9;

  // Attribute codes the block treats as fallbacks
  localparam logic [1:0] INTEN_SPARE = 2'd3;
  localparam logic [1:0] BLINK_SPARE = 2'd3;
  localparam logic [1:0] UL_SPARE    = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  trcp_pixel_if pix_ch ();
  trcp_color_if color_ch ();
  trcp_cfg_if   cfg_ch ();

  int fail_count;
  int pending_count;
  int checked_count;

  // Settings as last written, used to steer beats onto the cursor cell
  logic [trcp_pkg::CELL_ROW_W-1:0] cursor_row_set;
  logic [trcp_pkg::CELL_COL_W-1:0] cursor_col_set;
  int                              settings_run;
  int                              cursor_hits;
  int                              burst_left;

  always #CLK_HALF clk = ~clk;

  text_cell_pixel_renderer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_ch),
    .out_ch (color_ch),
    .cfg_ch (cfg_ch)
  );

  text_cell_pixel_renderer_checker CHECK (
    .clk           (clk),
    .rst_n         (rst_n),
    .px_mon        (pix_ch),
    .color_mon     (color_ch),
    .cfg_mon       (cfg_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  function automatic logic [trcp_pkg::ATTR_W-1:0] attr_word(
    input logic [3:0] fg,
    input logic [3:0] bg,
    input logic [1:0] inten,
    input logic       negative,
    input logic [1:0] blink,
    input logic [1:0] ul
  );
    return {ul, blink, negative, inten, bg, fg};
  endfunction

  function automatic trcp_pkg::pixel_in_t pixel_at(
    input int                           crow,
    input int                           ccol,
    input int                           prow,
    input int                           pcol,
    input logic [trcp_pkg::ATTR_W-1:0]  attr,
    input logic [trcp_pkg::GLYPH_W-1:0] bits,
    input int                           wide,
    input int                           tall
  );
    trcp_pkg::pixel_in_t p;
    p.cell_row        = trcp_pkg::CELL_ROW_W'(crow);
    p.cell_column     = trcp_pkg::CELL_COL_W'(ccol);
    p.pixel_row       = trcp_pkg::PIX_ROW_W'(prow);
    p.pixel_column    = trcp_pkg::PIX_COL_W'(pcol);
    p.cell_attributes = attr;
    p.glyph_row_bits  = bits;
    p.glyph_bits_wide = trcp_pkg::GLYPH_SIZE_W'(wide);
    p.glyph_rows_tall = trcp_pkg::GLYPH_SIZE_W'(tall);
    return p;
  endfunction

  function automatic logic [3:0] random_color();
    if ($urandom_range(0, 7) == 0) return 4'($urandom_range(LAST_COLOR + 1, 15));
    return 4'($urandom_range(0, LAST_COLOR));
  endfunction

  // Mostly well-formed pixels inside the glyph box; some pure noise
  function automatic trcp_pkg::pixel_in_t random_pixel();
    trcp_pkg::pixel_in_t p;
    int                  wide;
    int                  tall;
    if ($urandom_range(0, 9) == 0) begin
      p.cell_row        = trcp_pkg::CELL_ROW_W'($urandom);
      p.cell_column     = trcp_pkg::CELL_COL_W'($urandom);
      p.pixel_row       = trcp_pkg::PIX_ROW_W'($urandom);
      p.pixel_column    = trcp_pkg::PIX_COL_W'($urandom);
      p.cell_attributes = trcp_pkg::ATTR_W'($urandom);
      p.glyph_row_bits  = trcp_pkg::GLYPH_W'($urandom);
      p.glyph_bits_wide = trcp_pkg::GLYPH_SIZE_W'($urandom);
      p.glyph_rows_tall = trcp_pkg::GLYPH_SIZE_W'($urandom);
      return p;
    end
    wide = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
    tall = $urandom_range(1, 12);
    if ($urandom_range(0, 3) == 0) begin
      p.cell_row    = cursor_row_set;
      p.cell_column = cursor_col_set;
    end else begin
      p.cell_row    = trcp_pkg::CELL_ROW_W'($urandom_range(0, 31));
      p.cell_column = trcp_pkg::CELL_COL_W'($urandom_range(0, 63));
    end
    // Aim at the underline rows often
    case ($urandom_range(0, 4))
      0:       p.pixel_row = trcp_pkg::PIX_ROW_W'(tall - 1);
      1:       p.pixel_row = trcp_pkg::PIX_ROW_W'((tall >= 2) ? tall - 2 : 0);
      default: p.pixel_row = trcp_pkg::PIX_ROW_W'($urandom_range(0, 11));
    endcase
    if (wide > 0 && $urandom_range(0, 3) != 0)
      p.pixel_column = trcp_pkg::PIX_COL_W'($urandom_range(0, wide - 1));
    else
      p.pixel_column = trcp_pkg::PIX_COL_W'($urandom_range(0, 7));
    p.cell_attributes = attr_word(random_color(), random_color(), 2'($urandom_range(0, 3)),
                                  1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                                  2'($urandom_range(0, 3)));
    p.glyph_row_bits  = trcp_pkg::GLYPH_W'($urandom);
    p.glyph_bits_wide = trcp_pkg::GLYPH_SIZE_W'(wide);
    p.glyph_rows_tall = trcp_pkg::GLYPH_SIZE_W'(tall);
    return p;
  endfunction

  task automatic drive_pixel(input trcp_pkg::pixel_in_t p);
    pix_ch.cell_row        = p.cell_row;
    pix_ch.cell_column     = p.cell_column;
    pix_ch.pixel_row       = p.pixel_row;
    pix_ch.pixel_column    = p.pixel_column;
    pix_ch.cell_attributes = p.cell_attributes;
    pix_ch.glyph_row_bits  = p.glyph_row_bits;
    pix_ch.glyph_bits_wide = p.glyph_bits_wide;
    pix_ch.glyph_rows_tall = p.glyph_rows_tall;
  endtask

  // Send one beat; open a random gap, if gaps are on, whenever a burst runs out
  task automatic send_pixel(input trcp_pkg::pixel_in_t p, input bit gaps_on);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on) begin
        repeat ($urandom_range(0, 6)) begin
          @(negedge clk);
          pix_ch.valid = 1'b0;
        end
      end
    end
    burst_left--;
    @(negedge clk);
    drive_pixel(p);
    pix_ch.valid = 1'b1;
    if (p.cell_row == cursor_row_set && p.cell_column == cursor_col_set) cursor_hits++;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
  endtask

  // Hold the sender until every predicted pixel has come back
  task automatic drain_results();
    @(negedge clk);
    pix_ch.valid = 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input trcp_pkg::cfg_reg_t idx,
                           input logic [trcp_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic apply_settings(
    input logic                            fast,
    input logic                            slow,
    input logic [trcp_pkg::CELL_ROW_W-1:0] crow,
    input logic [trcp_pkg::CELL_COL_W-1:0] ccol,
    input logic                            shown
  );
    write_reg(trcp_pkg::CFG_FAST_BLINK_PHASE, trcp_pkg::CFG_DATA_W'(fast));
    write_reg(trcp_pkg::CFG_SLOW_BLINK_PHASE, trcp_pkg::CFG_DATA_W'(slow));
    write_reg(trcp_pkg::CFG_CURSOR_ROW, trcp_pkg::CFG_DATA_W'(crow));
    write_reg(trcp_pkg::CFG_CURSOR_COLUMN, trcp_pkg::CFG_DATA_W'(ccol));
    write_reg(trcp_pkg::CFG_CURSOR_SHOWN, trcp_pkg::CFG_DATA_W'(shown));
    cursor_row_set = crow;
    cursor_col_set = ccol;
    settings_run++;
  endtask

  // Result side: cycle through always ready, light, heavy and periodic stalls
  initial begin : result_sink
    int cyc;
    cyc = 0;
    color_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      cyc++;
      case ((cyc / 256) % 4)
        0:       color_ch.ready = 1'b1;
        1:       color_ch.ready = ($urandom_range(0, 3) != 0);
        2:       color_ch.ready = 1'($urandom_range(0, 1));
        default: color_ch.ready = ((cyc % 8) >= 5);
      endcase
    end
  end

  initial begin : stimulus
    trcp_pkg::pixel_in_t directed_px[$];
    int                  phase;
    bit                  gaps_on;

    pix_ch.valid = 1'b0;
    drive_pixel('0);
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = trcp_pkg::CFG_FAST_BLINK_PHASE;
    cfg_ch.data    = '0;
    cursor_row_set = '0;
    cursor_col_set = '0;
    settings_run   = 0;
    cursor_hits    = 0;
    burst_left     = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: fast phase on, slow phase off, cursor at row 1 column 2
    apply_settings(1'b1, 1'b0, 5'd1, 6'd2, 1'b1);
    directed_px.push_back(pixel_at(0, 0, 0, 0,
      attr_word(0, 1, trcp_pkg::INTEN_NORMAL, 0, trcp_pkg::BLINK_OFF, trcp_pkg::UL_NONE),
      8'h80, 8, 12));
    directed_px.push_back(pixel_at(0, 1, 0, 0,
      attr_word(0, 1, trcp_pkg::INTEN_NORMAL, 0, trcp_pkg::BLINK_OFF, trcp_pkg::UL_NONE),
      8'h00, 8, 12));
    // all ones: outside the cell
    directed_px.push_back(pixel_at(31, 63, 15, 7, '1, 8'hff, 15, 15));
    // widest glyph clamped to eight dots, last column
    directed_px.push_back(pixel_at(31, 63, 11, 7,
      attr_word(8, 8, trcp_pkg::INTEN_BOLD, 0, trcp_pkg::BLINK_OFF, trcp_pkg::UL_NONE),
      8'hff, 15, 12));
    // no glyph found
    directed_px.push_back(pixel_at(3, 3, 2, 0,
      attr_word(2, 3, trcp_pkg::INTEN_NORMAL, 0, trcp_pkg::BLINK_OFF, trcp_pkg::UL_NONE),
      8'hff, 0, 12));
    // below the glyph, right of the glyph, zero height
    directed_px.push_back(pixel_at(3, 4, 8, 1,
      attr_word(2, 3, trcp_pkg::INTEN_NORMAL, 0, trcp_pkg::BLINK_OFF, trcp_pkg::UL_NONE),
      8'hff, 8, 8));
    directed_px.push_back(pixel_at(3, 5, 1, 6,
      attr_word(2, 3, trcp_pkg::INTEN_NORMAL, 0, trcp_pkg::BLINK_OFF, trcp_pkg::UL_NONE),
      8'hff, 5, 12));
    directed_px.push_back(pixel_at(3, 6, 0, 0,
      attr_word(2, 3, trcp_pkg::INTEN_NORMAL, 0, trcp_pkg::BLINK_OFF, trcp_pkg::UL_NONE),
      8'hff, 8, 0));
    // intensities, including the unused code
    directed_px.push_back(pixel_at(4, 0, 3, 0,
      attr_word(2, 3, trcp_pkg::INTEN_FAINT, 0, trcp_pkg::BLINK_OFF, trcp_pkg::UL_NONE),
      8'h40, 7, 12));
    directed_px.push_back(pixel_at(4, 1, 3, 2,
      attr_word(4, 3, INTEN_SPARE, 0, trcp_pkg::BLINK_OFF, trcp_pkg::UL_NONE),
      8'h20, 8, 12));
    directed_px.push_back(pixel_at(4, 2, 3, 2,
      attr_word(7, 0, trcp_pkg::INTEN_BOLD, 0, trcp_pkg::BLINK_OFF, trcp_pkg::UL_NONE),
      8'h20, 8, 12));
    // polarity and blink
    directed_px.push_back(pixel_at(5, 0, 0, 0,
      attr_word(5, 6, trcp_pkg::INTEN_NORMAL, 1, trcp_pkg::BLINK_OFF, trcp_pkg::UL_NONE),
      8'h00, 8, 12));
    directed_px.push_back(pixel_at(5, 1, 0, 0,
      attr_word(6, 7, trcp_pkg::INTEN_NORMAL, 1, trcp_pkg::BLINK_LONG, trcp_pkg::UL_NONE),
      8'h80, 8, 12));
    directed_px.push_back(pixel_at(5, 2, 0, 0,
      attr_word(6, 7, trcp_pkg::INTEN_NORMAL, 0, trcp_pkg::BLINK_SHORT, trcp_pkg::UL_NONE),
      8'h80, 8, 12));
    directed_px.push_back(pixel_at(5, 3, 0, 0,
      attr_word(6, 7, trcp_pkg::INTEN_NORMAL, 0, BLINK_SPARE, trcp_pkg::UL_NONE),
      8'h80, 8, 12));
    // underline rows
    directed_px.push_back(pixel_at(6, 0, 9, 3,
      attr_word(3, 2, trcp_pkg::INTEN_NORMAL, 0, trcp_pkg::BLINK_OFF, trcp_pkg::UL_SINGLE),
      8'h00, 8, 10));
    directed_px.push_back(pixel_at(6, 1, 8, 3,
      attr_word(3, 2, trcp_pkg::INTEN_NORMAL, 0, trcp_pkg::BLINK_OFF, trcp_pkg::UL_DOUBLE),
      8'h00, 8, 10));
    directed_px.push_back(pixel_at(6, 2, 0, 3,
      attr_word(3, 2, trcp_pkg::INTEN_NORMAL, 0, trcp_pkg::BLINK_OFF, trcp_pkg::UL_DOUBLE),
      8'h00, 8, 1));
    directed_px.push_back(pixel_at(6, 3, 9, 3,
      attr_word(3, 2, trcp_pkg::INTEN_NORMAL, 0, trcp_pkg::BLINK_OFF, UL_SPARE),
      8'h00, 8, 10));
    // transparent color codes
    directed_px.push_back(pixel_at(7, 0, 0, 0,
      attr_word(9, 9, trcp_pkg::INTEN_NORMAL, 0, trcp_pkg::BLINK_OFF, trcp_pkg::UL_NONE),
      8'h80, 8, 12));
    directed_px.push_back(pixel_at(7, 1, 0, 0,
      attr_word(10, 15, trcp_pkg::INTEN_BOLD, 0, trcp_pkg::BLINK_OFF, trcp_pkg::UL_NONE),
      8'h00, 8, 12));
    // cursor cell, plain and negative
    directed_px.push_back(pixel_at(1, 2, 0, 0,
      attr_word(0, 1, trcp_pkg::INTEN_NORMAL, 0, trcp_pkg::BLINK_OFF, trcp_pkg::UL_NONE),
      8'h80, 8, 12));
    directed_px.push_back(pixel_at(1, 2, 0, 0,
      attr_word(0, 1, trcp_pkg::INTEN_NORMAL, 1, trcp_pkg::BLINK_OFF, trcp_pkg::UL_NONE),
      8'h80, 8, 12));
    directed_px.push_back(pixel_at(2, 2, 0, 7,
      attr_word(8, 5, trcp_pkg::INTEN_NORMAL, 0, trcp_pkg::BLINK_OFF, trcp_pkg::UL_NONE),
      8'h01, 8, 12));
    foreach (directed_px[i]) send_pixel(directed_px[i], 1'b1);
    drain_results();

    // Random phases; the first two pin every register to an extreme
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0)
        apply_settings(1'b0, 1'b0, '0, '0, 1'b0);
      else if (phase == 1)
        apply_settings(1'b1, 1'b1, '1, '1, 1'b1);
      else
        apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       trcp_pkg::CELL_ROW_W'($urandom_range(0, 31)),
                       trcp_pkg::CELL_COL_W'($urandom_range(0, 63)),
                       1'($urandom_range(0, 3) != 0));
      gaps_on = (phase != 2);
      repeat (PIXELS_PER_PHASE) send_pixel(random_pixel(), gaps_on);
      drain_results();
    end

    $display("Rendered %0d pixels checked across %0d register settings.",
             checked_count, settings_run);
    $display("%0d pixels fell on the cursor cell; bursts, gaps and stalls varied by phase.",
             cursor_hits);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
